@@ rtl/core/tmp_pkg.sv @@
// Shared constants, widths and helpers for the trapezoid motion profile block.
`default_nettype none
package tmp_pkg;
	// Distance and speed fraction bits; times always carry 16 fraction bits.
	localparam int FRACTION_BITS = 16;
	localparam int TIME_FRAC     = 16;
	// Finish window of 0.1 distance unit, rounded.
	localparam logic [31:0] TOLERANCE = 32'(((64'd1 << FRACTION_BITS) + 64'd5) / 64'd10);

	localparam int NUM_W  = 64;
	localparam int DEN_W  = 31;
	localparam int ROOT_W = 32;

	// Configuration register indexes.
	localparam logic [1:0] REG_MAX_SPEED = 2'd0;
	localparam logic [1:0] REG_MAX_ACCEL = 2'd1;
	localparam logic [1:0] REG_TICK      = 2'd2;

	// Output phase codes.
	localparam logic [1:0] PH_ACCEL  = 2'd0;
	localparam logic [1:0] PH_CRUISE = 2'd1;
	localparam logic [1:0] PH_DECEL  = 2'd2;
	localparam logic [1:0] PH_DONE   = 2'd3;

	// Saturate a wide quotient to 32 bits.
	function automatic logic [31:0] sat32(input logic [NUM_W-1:0] v);
		sat32 = (|v[NUM_W-1:32]) ? 32'hFFFF_FFFF : v[31:0];
	endfunction
endpackage
`default_nettype wire

@@ rtl/core/tmp_div.sv @@
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none
module tmp_div (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [tmp_pkg::NUM_W-1:0] num,
	input  wire logic [tmp_pkg::DEN_W-1:0] den,
	output logic                           done,
	output logic [tmp_pkg::NUM_W-1:0]      quo
);
	import tmp_pkg::*;

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] work_q;
	logic [DEN_W-1:0] rem_q;
	logic             done_q;
	logic [DEN_W:0]   shifted;
	logic             fits;

	// Trial subtraction of the divisor from the shifted remainder.
	assign shifted = {rem_q, work_q[NUM_W-1]};
	assign fits    = shifted >= {1'b0, den};

	// Control: count the steps and flag the last one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_W'(NUM_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: the dividend shifts out while quotient bits shift in.
	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= num;
			rem_q  <= '0;
		end else if (cnt_q != '0) begin
			if (fits) begin
				rem_q <= DEN_W'(shifted - {1'b0, den});
			end else begin
				rem_q <= shifted[DEN_W-1:0];
			end
			work_q <= {work_q[NUM_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = work_q;
endmodule
`default_nettype wire

@@ rtl/core/tmp_sqrt.sv @@
// Digit-by-digit integer square root, one root bit per cycle.
`default_nettype none
module tmp_sqrt (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [tmp_pkg::NUM_W-1:0] radicand,
	output logic                           done,
	output logic [tmp_pkg::ROOT_W-1:0]     root
);
	import tmp_pkg::*;

	localparam int CNT_W = $clog2(ROOT_W + 1);
	localparam int REM_W = ROOT_W + 1;

	logic [CNT_W-1:0]  cnt_q;
	logic [NUM_W-1:0]  rad_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;
	logic              done_q;
	logic [REM_W+1:0]  partial;
	logic [REM_W+1:0]  trial;
	logic              fits;

	// Bring down two radicand bits and try the next root bit.
	assign partial = {rem_q, rad_q[NUM_W-1:NUM_W-2]};
	assign trial   = {1'b0, root_q, 2'b01};
	assign fits    = partial >= trial;

	// Control: count the root bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_W'(ROOT_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: remainder and root update.
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (cnt_q != '0) begin
			if (fits) begin
				rem_q <= REM_W'(partial - trial);
			end else begin
				rem_q <= partial[REM_W-1:0];
			end
			root_q <= {root_q[ROOT_W-2:0], fits};
			rad_q  <= {rad_q[NUM_W-3:0], 2'b00};
		end
	end

	assign done = done_q;
	assign root = root_q;
endmodule
`default_nettype wire

@@ rtl/core/trapezoid_motion_profile.sv @@
// Trapezoidal velocity profile planner and stepper, top level.
//
// Input beats on s_*: s_tuser is the opcode (1 starts a move, 0 is one tick),
// s_tdata is the signed Q16.16 move distance, read only on a start.
// Every input beat yields one output beat on m_*: m_tdata holds the signed
// speed and the travelled distance, m_tuser the done flag and the phase.
// Registers max_speed, max_accel and tick_seconds are written on cfg_*; the user must
// write them only while the block is idle, not enforced here; cfg_ready is always high.
// One item is processed at a time through a shared 32x32 multiplier, a
// one-bit-per-cycle divider and a one-bit-per-cycle square root unit.
// A tick runs the multiplier sequence, or goes straight to the result once the
// profile has finished; a start runs three divisions, plus the square root when
// the profile is triangular.
// s_tready is high only while idle. A finished result waits in the output
// register while the next item is accepted; a stalled receiver holds the
// block only when a second result is ready before the first is taken.
// Reset restores the default registers and leaves the profile finished.
`default_nettype none
module trapezoid_motion_profile (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // [31:0] move_distance
	input  wire logic        s_tuser,   // [0] opcode
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [63:0]      m_tdata,   // [31:0] speed_out, [62:32] position_out, [63] zero
	output logic [2:0]       m_tuser,   // [0] move_done, [2:1] phase
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [30:0] cfg_data
);
	import tmp_pkg::*;

	// Sequencer state codes.
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_AT   = 4'd1;
	localparam logic [3:0] S_TWR  = 4'd2;
	localparam logic [3:0] S_CMP  = 4'd3;
	localparam logic [3:0] S_CR   = 4'd4;
	localparam logic [3:0] S_SQD  = 4'd5;
	localparam logic [3:0] S_SQ   = 4'd6;
	localparam logic [3:0] S_T0   = 4'd7;
	localparam logic [3:0] S_T1   = 4'd8;
	localparam logic [3:0] S_T2   = 4'd9;
	localparam logic [3:0] S_T3   = 4'd10;
	localparam logic [3:0] S_T4   = 4'd11;
	localparam logic [3:0] S_T5   = 4'd12;
	localparam logic [3:0] S_T6   = 4'd13;
	localparam logic [3:0] S_T7   = 4'd14;
	localparam logic [3:0] S_FIN  = 4'd15;

	// Clamp a signed 34-bit value into the 31-bit magnitude range.
	function automatic logic [30:0] clamp31(input logic [33:0] v);
		if (v[33]) begin
			clamp31 = '0;
		end else if (|v[32:31]) begin
			clamp31 = 31'h7FFF_FFFF;
		end else begin
			clamp31 = v[30:0];
		end
	endfunction

	logic [3:0]  state_q;
	logic [30:0] max_speed_q, max_accel_q;
	logic [15:0] tick_q;
	logic [30:0] pos_q, spd_q, total_q;
	logic [31:0] elapsed_q, at_q, cruise_q, sspd_q;
	logic        neg_q, finished_q;
	logic [1:0]  ph_q;
	logic        over_q;
	logic [30:0] adt_q, vdt_q;
	logic [29:0] half_q;
	logic [31:0] dd_q;
	logic [61:0] twr_q;
	logic [63:0] prod_q;
	logic        out_valid_q;
	logic [63:0] out_data_q;
	logic [2:0]  out_user_q;

	logic [30:0] vm, am;
	logic [31:0] mul_a, mul_b;
	logic        div_start, div_done;
	logic        sq_start, sq_done;
	logic [NUM_W-1:0]  div_num;
	logic [DEN_W-1:0]  div_den;
	logic [NUM_W-1:0]  div_quo;
	logic [ROOT_W-1:0] sq_root;
	logic [31:0] raw_mag;
	logic [31:0] at_plus_cr_lo;
	logic        at_plus_cr_hi;
	logic [33:0] over_limit;
	logic [33:0] pos_sum;
	logic [33:0] spd_sum;
	logic        fin_now;
	logic [30:0] spd_fin;
	logic [32:0] elapsed_sum;
	logic        accept;

	assign vm     = (max_speed_q == '0) ? 31'd1 : max_speed_q;
	assign am     = (max_accel_q == '0) ? 31'd1 : max_accel_q;
	assign accept = s_tvalid && s_tready;

	assign s_tready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_speed_q <= 31'd65536;
			max_accel_q <= 31'd65536;
			tick_q      <= 16'd66;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_MAX_SPEED: max_speed_q <= cfg_data;
				REG_MAX_ACCEL: max_accel_q <= cfg_data;
				REG_TICK:      tick_q      <= cfg_data[15:0];
				default:       ;
			endcase
		end
	end

	// Shared multiplier operand selection; the product is always registered.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_AT: begin
				mul_a = {1'b0, vm};
				mul_b = {1'b0, vm};
			end
			S_T0: begin
				mul_a = {1'b0, am};
				mul_b = {16'd0, tick_q};
			end
			S_T1: begin
				mul_a = {16'd0, tick_q};
				mul_b = {16'd0, tick_q};
			end
			S_T3: begin
				mul_a = {1'b0, am};
				mul_b = dd_q;
			end
			S_T4: begin
				mul_a = (ph_q == PH_CRUISE) ? {1'b0, vm} : {1'b0, spd_q};
				mul_b = {16'd0, tick_q};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// Divider operands and start strobes; the divisor is held for the whole division.
	assign raw_mag = s_tdata[31] ? (32'd0 - s_tdata) : s_tdata;

	always_comb begin
		div_start = 1'b0;
		div_num   = '0;
		div_den   = am;
		sq_start  = 1'b0;
		case (state_q)
			S_IDLE: begin
				div_start = accept && s_tuser;
				div_num   = {17'd0, vm, 16'd0};
			end
			S_AT: begin
				div_start = div_done;
				div_num   = prod_q;
			end
			S_CMP: begin
				div_start = 1'b1;
				if ({31'd0, total_q} > twr_q) begin
					div_num = {17'd0, 31'(total_q - twr_q[30:0]), 16'd0};
					div_den = vm;
				end else begin
					div_num = {1'b0, total_q, 32'd0};
				end
			end
			S_CR: begin
				div_den = vm;
			end
			S_SQD: begin
				sq_start = div_done;
			end
			default: ;
		endcase
	end

	tmp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	tmp_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (div_quo),
		.done     (sq_done),
		.root     (sq_root)
	);

	// Phase tests on the elapsed time before the step.
	assign {at_plus_cr_hi, at_plus_cr_lo} = {1'b0, at_q} + {1'b0, cruise_q};
	assign over_limit = {2'b00, at_q} + {2'b00, at_q} + {2'b00, cruise_q};

	// Position and speed for the current phase.
	always_comb begin
		pos_sum = {3'd0, pos_q} + {3'd0, vdt_q};
		spd_sum = {3'd0, spd_q};
		case (ph_q)
			PH_ACCEL: begin
				pos_sum = pos_sum + {4'd0, half_q};
				spd_sum = spd_sum + {3'd0, adt_q};
			end
			PH_CRUISE: begin
				spd_sum = {3'd0, vm};
			end
			default: begin
				pos_sum = pos_sum - {4'd0, half_q};
				spd_sum = spd_sum - {3'd0, adt_q};
			end
		endcase
	end

	// Finish test and the values that follow from it.
	assign fin_now     = ({1'b0, pos_q} + {1'b0, TOLERANCE} >= {2'b00, total_q}) || over_q;
	assign spd_fin     = fin_now ? 31'd0 : spd_q;
	assign elapsed_sum = {1'b0, elapsed_q} + {17'd0, tick_q};

	// Main sequencer and profile state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pos_q       <= '0;
			spd_q       <= '0;
			total_q     <= '0;
			elapsed_q   <= '0;
			at_q        <= '0;
			cruise_q    <= '0;
			sspd_q      <= '0;
			neg_q       <= 1'b0;
			finished_q  <= 1'b1;
			ph_q        <= PH_ACCEL;
			over_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (s_tuser) begin
							total_q    <= (raw_mag[31]) ? 31'h7FFF_FFFF : raw_mag[30:0];
							neg_q      <= s_tdata[31] || (s_tdata == '0);
							finished_q <= 1'b0;
							pos_q      <= '0;
							spd_q      <= '0;
							elapsed_q  <= '0;
							sspd_q     <= '0;
							ph_q       <= PH_ACCEL;
							state_q    <= S_AT;
						end else if (finished_q) begin
							ph_q    <= PH_DONE;
							state_q <= S_FIN;
						end else begin
							state_q <= S_T0;
						end
					end
				end
				S_AT: begin
					if (div_done) begin
						at_q    <= sat32(div_quo);
						state_q <= S_TWR;
					end
				end
				S_TWR: begin
					if (div_done) begin
						twr_q   <= div_quo[61:0];
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					state_q <= ({31'd0, total_q} > twr_q) ? S_CR : S_SQD;
				end
				S_CR: begin
					if (div_done) begin
						cruise_q <= sat32(div_quo);
						state_q  <= S_FIN;
					end
				end
				S_SQD: begin
					if (div_done) begin
						state_q <= S_SQ;
					end
				end
				S_SQ: begin
					if (sq_done) begin
						at_q     <= sq_root;
						cruise_q <= '0;
						state_q  <= S_FIN;
					end
				end
				S_T0: begin
					if (elapsed_q < at_q) begin
						ph_q <= PH_ACCEL;
					end else if ({1'b0, elapsed_q} < {at_plus_cr_hi, at_plus_cr_lo}) begin
						ph_q <= PH_CRUISE;
					end else begin
						ph_q <= PH_DECEL;
					end
					over_q  <= {2'b00, elapsed_q} > over_limit;
					state_q <= S_T1;
				end
				S_T1: begin
					adt_q   <= prod_q[46:16];
					state_q <= S_T2;
				end
				S_T2: begin
					dd_q    <= prod_q[31:0];
					state_q <= S_T3;
				end
				S_T3: begin
					state_q <= S_T4;
				end
				S_T4: begin
					half_q  <= prod_q[62:33];
					state_q <= S_T5;
				end
				S_T5: begin
					vdt_q   <= prod_q[46:16];
					state_q <= S_T6;
				end
				S_T6: begin
					pos_q   <= clamp31(pos_sum);
					spd_q   <= clamp31(spd_sum);
					state_q <= S_T7;
				end
				S_T7: begin
					if (fin_now) begin
						pos_q      <= total_q;
						spd_q      <= '0;
						finished_q <= 1'b1;
						ph_q       <= PH_DONE;
						elapsed_q  <= {16'd0, tick_q};
					end else begin
						elapsed_q <= elapsed_sum[32] ? 32'hFFFF_FFFF : elapsed_sum[31:0];
					end
					sspd_q  <= neg_q ? (32'd0 - {1'b0, spd_fin}) : {1'b0, spd_fin};
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (!out_valid_q || m_tready) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Output payload register, loaded as the result is handed over.
	always_ff @(posedge clk) begin
		if (state_q == S_FIN && (!out_valid_q || m_tready)) begin
			out_data_q <= {1'b0, pos_q, sspd_q};
			out_user_q <= {ph_q, finished_q};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

`ifndef SYNTHESIS
	// A finished profile always rests exactly at its target distance.
	a_rest_at_target: assert property (@(posedge clk) disable iff (!arst_n)
		finished_q |-> (pos_q == total_q))
		else $error("finished profile away from target");

	// An accepted item keeps the block busy on the following cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input taken while busy");

	// The done flag and the done phase always travel together.
	a_done_phase: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser[0] == (m_tuser[2:1] == PH_DONE)))
		else $error("done flag and phase disagree");
`endif
endmodule
`default_nettype wire

@@ sim/trapezoid_motion_profile_tb.sv @@
// Self-checking testbench for the trapezoid motion profile block.
`timescale 1ns / 100ps
`default_nettype none
module trapezoid_motion_profile_tb;
	import tmp_pkg::*;

	typedef struct packed {
		logic        start;
		logic [31:0] move_dist;
	} move_cmd_t;

	typedef struct packed {
		logic [31:0] spd;
		logic [30:0] pos;
		logic        done;
		logic [1:0]  ph;
	} motion_out_t;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int RX_LONG_CYCLES = 400;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;
	logic [2:0]  m_tuser;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [30:0] cfg_data;

	trapezoid_motion_profile u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Clock with a 2 ns period.
	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// Predictor copy of the block's registers and profile state.
	logic [30:0] pm_vmax, pm_amax;
	logic [15:0] pm_dt;
	logic [31:0] pm_pos, pm_spd, pm_elapsed, pm_t_acc, pm_t_cruise, pm_dist, pm_sspd;
	logic        pm_neg, pm_finished;

	move_cmd_t   pending_moves[$];
	motion_out_t expected_outputs[$];
	int          n_errors;
	int          n_sent;
	int          n_checked;
	int          idle_cycles;
	int          rx_hold;
	int          rx_long;
	bit          rx_long_req;
	bit          tx_fire;
	bit          stim_done;

	function automatic logic [31:0] sat_to32(input logic [63:0] v);
		return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
	endfunction

	function automatic logic [31:0] clamp_to_pos(input longint v);
		if (v < 0)
			return 32'd0;
		if (v > longint'(32'h7FFF_FFFF))
			return 32'h7FFF_FFFF;
		return v[31:0];
	endfunction

	function automatic logic [63:0] int_sqrt(input logic [63:0] n);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n)
			b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// Advance the predicted profile by one beat and return its result.
	function automatic motion_out_t step_profile(input move_cmd_t cmd);
		motion_out_t r;
		logic [63:0] vm, am, dt, mag, ramp2, adt;
		longint      half, vdt;
		logic [1:0]  ph;
		vm = (pm_vmax == 0) ? 64'd1 : 64'(pm_vmax);
		am = (pm_amax == 0) ? 64'd1 : 64'(pm_amax);
		dt = 64'(pm_dt);
		ph = PH_DONE;
		if (cmd.start) begin
			mag = cmd.move_dist[31] ? 64'(32'(~cmd.move_dist + 32'd1)) : 64'(cmd.move_dist);
			if (mag > 64'h7FFF_FFFF)
				mag = 64'h7FFF_FFFF;
			pm_dist = mag[31:0];
			pm_neg = cmd.move_dist[31] || cmd.move_dist == 0;
			pm_finished = 1'b0;
			pm_pos = 0;
			pm_spd = 0;
			pm_elapsed = 0;
			pm_sspd = 0;
			pm_t_acc = sat_to32((vm << 16) / am);
			ramp2 = (vm * vm) / am;
			if (mag > ramp2) begin
				pm_t_cruise = sat_to32(((mag - ramp2) << 16) / vm);
			end else begin
				pm_t_acc = sat_to32(int_sqrt((mag << 32) / am));
				pm_t_cruise = 0;
			end
			return '0;
		end
		if (!pm_finished) begin
			adt = (am * dt) >> 16;
			half = longint'((am * dt * dt) >> 33);
			if (pm_elapsed < pm_t_acc) begin
				ph = PH_ACCEL;
				vdt = longint'((64'(pm_spd) * dt) >> 16);
				pm_pos = clamp_to_pos(longint'(pm_pos) + vdt + half);
				pm_spd = clamp_to_pos(longint'(pm_spd) + longint'(adt));
			end else if (64'(pm_elapsed) < 64'(pm_t_acc) + 64'(pm_t_cruise)) begin
				ph = PH_CRUISE;
				pm_spd = vm[31:0];
				pm_pos = clamp_to_pos(longint'(pm_pos) + longint'((vm * dt) >> 16));
			end else begin
				ph = PH_DECEL;
				vdt = longint'((64'(pm_spd) * dt) >> 16);
				pm_pos = clamp_to_pos(longint'(pm_pos) + vdt - half);
				pm_spd = clamp_to_pos(longint'(pm_spd) - longint'(adt));
			end
			if (longint'(pm_pos) >= longint'(pm_dist) - longint'(TOLERANCE) ||
			    64'(pm_elapsed) > 2 * 64'(pm_t_acc) + 64'(pm_t_cruise)) begin
				pm_pos = pm_dist;
				pm_spd = 0;
				pm_elapsed = 0;
				pm_finished = 1'b1;
				ph = PH_DONE;
			end
			pm_sspd = pm_neg ? 32'd0 - pm_spd : pm_spd;
			pm_elapsed = sat_to32(64'(pm_elapsed) + dt);
		end
		r.spd = pm_sspd;
		r.pos = pm_pos[30:0];
		r.done = pm_finished;
		r.ph = ph;
		return r;
	endfunction

	// Random gap length: mostly short, sometimes long.
	function automatic int pick_gap();
		int k;
		k = $urandom_range(0, 99);
		if (k < 50)
			return 0;
		if (k < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Remember whether the offered beat was taken at the last rising edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_fire <= 1'b0;
		end else begin
			tx_fire <= s_tvalid && s_tready;
		end
	end

	// Driver: offers queued moves on the input stream.
	int tx_gap;
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= 1'b0;
			tx_gap <= 0;
		end else if (s_tvalid && !tx_fire) begin
			// Hold the current beat.
		end else if (tx_gap > 0) begin
			s_tvalid <= 1'b0;
			tx_gap <= tx_gap - 1;
		end else if (pending_moves.size() > 0) begin
			s_tvalid <= 1'b1;
			s_tuser <= pending_moves[0].start;
			s_tdata <= pending_moves[0].move_dist;
			void'(pending_moves.pop_front());
			tx_gap <= pick_gap();
		end else begin
			s_tvalid <= 1'b0;
		end
	end

	// Receiver backpressure, with a long hold-off on request.
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_hold <= 0;
			rx_long <= 0;
		end else if (rx_long > 0) begin
			m_tready <= 1'b0;
			rx_long <= rx_long - 1;
		end else if (rx_long_req) begin
			m_tready <= 1'b0;
			rx_long <= RX_LONG_CYCLES;
		end else if (rx_hold > 0) begin
			m_tready <= 1'b0;
			rx_hold <= rx_hold - 1;
		end else begin
			m_tready <= 1'b1;
			rx_hold <= pick_gap();
		end
	end

	// Monitor: predicts on accepted inputs and checks accepted outputs.
	always @(posedge clk) begin
		motion_out_t got, want;
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			if (s_tvalid && s_tready) begin
				expected_outputs.push_back(step_profile('{start: s_tuser, move_dist: s_tdata}));
				n_sent <= n_sent + 1;
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_MAX_SPEED: pm_vmax = cfg_data;
					REG_MAX_ACCEL: pm_amax = cfg_data;
					REG_TICK:      pm_dt = cfg_data[15:0];
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				got.spd = m_tdata[31:0];
				got.pos = m_tdata[62:32];
				got.done = m_tuser[0];
				got.ph = m_tuser[2:1];
				n_checked <= n_checked + 1;
				if (expected_outputs.size() == 0) begin
					$display("%0t: unexpected result %h", $time, got);
					n_errors <= n_errors + 1;
				end else begin
					want = expected_outputs.pop_front();
					if (got.spd !== want.spd || got.pos !== want.pos ||
					    got.done !== want.done || got.ph !== want.ph) begin
						$display("%0t: mismatch expected spd=%h pos=%h done=%b ph=%0d",
							$time, want.spd, want.pos, want.done, want.ph);
						$display("%0t:          actual   spd=%h pos=%h done=%b ph=%0d",
							$time, got.spd, got.pos, got.done, got.ph);
						n_errors <= n_errors + 1;
					end
				end
			end
		end
	end

	// Watchdog on cycles without any accepted beat.
	always @(posedge clk) begin
		if (idle_cycles > WATCHDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic wait_drained();
		while (pending_moves.size() > 0 || s_tvalid || expected_outputs.size() > 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [30:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic queue_move(input logic [31:0] d, input int ticks);
		pending_moves.push_back('{start: 1'b1, move_dist: d});
		repeat (ticks)
			pending_moves.push_back('{start: 1'b0, move_dist: $urandom});
	endtask

	// Random well-formed moves with a few stray items.
	task automatic random_moves(input int n_items);
		int cnt;
		int t;
		cnt = 0;
		while (cnt < n_items) begin
			if ($urandom_range(0, 9) == 0) begin
				pending_moves.push_back('{start: 1'($urandom), move_dist: $urandom});
				cnt++;
			end else begin
				t = $urandom_range(1, 40);
				case ($urandom_range(0, 3))
					0: queue_move($urandom, t);
					1: queue_move(32'($urandom_range(0, 32'h0004_0000)), t);
					2: queue_move(-32'($urandom_range(0, 32'h0004_0000)), t);
					default: queue_move(32'($urandom_range(0, 32'h0000_4000)), t);
				endcase
				cnt += t + 1;
			end
		end
	endtask

	initial begin
		pm_vmax = 31'd65536;
		pm_amax = 31'd65536;
		pm_dt = 16'd66;
		pm_pos = 0; pm_spd = 0; pm_elapsed = 0; pm_t_acc = 0; pm_t_cruise = 0;
		pm_dist = 0; pm_sspd = 0; pm_neg = 0; pm_finished = 1'b1;
		n_errors = 0; n_sent = 0; n_checked = 0; idle_cycles = 0;
		rx_long_req = 0; stim_done = 0;
		cfg_valid = 0; cfg_index = REG_MAX_SPEED; cfg_data = '0;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: ticks while idle, extreme and signed distances, zero distance.
		pending_moves.push_back('{start: 1'b0, move_dist: 32'hFFFF_FFFF});
		queue_move(32'h0000_0000, 2);
		queue_move(32'h8000_0000, 2);
		queue_move(32'h7FFF_FFFF, 2);
		queue_move(32'hFFFF_FFFF, 2);
		queue_move(32'h0001_8000, 6);
		queue_move(32'hFFFE_0000, 6);
		wait_drained();

		// Fast ramp so that moves reach cruise and finish quickly.
		write_reg(REG_MAX_SPEED, 31'h0002_0000);
		write_reg(REG_MAX_ACCEL, 31'h0040_0000);
		write_reg(REG_TICK, 31'h0000_2000);
		queue_move(32'h0008_0000, 20);
		queue_move(32'hFFFC_0000, 20);
		wait_drained();

		// Register extremes, including zero values treated as one.
		write_reg(REG_MAX_SPEED, 31'h7FFF_FFFF);
		write_reg(REG_MAX_ACCEL, 31'h7FFF_FFFF);
		write_reg(REG_TICK, 31'h0000_FFFF);
		queue_move(32'h7FFF_FFFF, 6);
		queue_move(32'h8000_0000, 6);
		wait_drained();
		write_reg(REG_MAX_SPEED, 31'd0);
		write_reg(REG_MAX_ACCEL, 31'd0);
		write_reg(REG_TICK, 31'd1);
		queue_move(32'h0000_0001, 4);
		queue_move(32'h5555_AAAA, 4);
		wait_drained();

		// Stall the receiver while the sender keeps offering.
		write_reg(REG_MAX_SPEED, 31'h0001_0000);
		write_reg(REG_MAX_ACCEL, 31'h0010_0000);
		write_reg(REG_TICK, 31'h0000_1000);
		queue_move(32'h0003_0000, 20);
		rx_long_req = 1;
		wait (rx_long > 0);
		rx_long_req = 0;
		wait (rx_long == 0);
		wait_drained();

		// Random phases with random register settings.
		for (int p = 0; p < 6; p++) begin
			write_reg(REG_MAX_SPEED, 31'($urandom_range(1, 32'h0008_0000)));
			write_reg(REG_MAX_ACCEL, 31'($urandom_range(1, 32'h0080_0000)));
			write_reg(REG_TICK, 31'($urandom_range(1, 16'hFFFF)));
			random_moves(180);
			wait_drained();
		end
		write_reg(REG_MAX_SPEED, 31'($urandom));
		write_reg(REG_MAX_ACCEL, 31'($urandom));
		write_reg(REG_TICK, 31'($urandom));
		random_moves(100);
		wait_drained();

		$display("Covered %0d input beats and %0d checked results over directed,",
			n_sent, n_checked);
		$display("stalled and randomized register settings.");
		if (n_errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end
endmodule
`default_nettype wire
